/* rtl/audio_level_envelope_macros.svh */
// assertion macros for the audio level envelope block
// clocked on clk, disabled while arst_n is low
`ifndef AUDIO_LEVEL_ENVELOPE_MACROS_SVH
`define AUDIO_LEVEL_ENVELOPE_MACROS_SVH

`ifndef SYNTHESIS
`define ALE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ale assertion failed");
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ale assertion failed");
`else
`define ALE_ASSERT_IMPL(lbl, ante, cons)
`define ALE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/ale_pkg.sv */
package ale_pkg;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               block_end;
	} ale_sample_t;

	typedef struct packed {
		logic [15:0] level;
		logic [15:0] volume;
	} ale_level_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_MAC,
		ST_OUT
	} ale_state_t;

	// q16 history weights, oldest first
	localparam logic [15:0] W_OLDEST = 16'd786;
	localparam logic [15:0] W_OLD    = 16'd7995;
	localparam logic [15:0] W_RECENT = 16'd31719;
	localparam logic [15:0] W_NEWEST = 16'd50201;

	// full scale of a q0.15 value
	localparam logic [15:0] VOL_MAX = 16'd32768;

	localparam int SQRT_STEPS = 16;
	localparam int HIST_DEPTH = 4;

	function automatic logic [15:0] ale_weight(input logic [1:0] idx);
		logic [15:0] w;
		case (idx)
			2'd0: w = W_OLDEST;
			2'd1: w = W_OLD;
			2'd2: w = W_RECENT;
			2'd3: w = W_NEWEST;
			default: w = W_OLDEST;
		endcase
		return w;
	endfunction

endpackage

/* rtl/ale_sample_if.sv */
interface ale_sample_if;
	import ale_pkg::*;

	logic        valid;
	logic        ready;
	ale_sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/ale_level_if.sv */
interface ale_level_if;
	import ale_pkg::*;

	logic       valid;
	logic       ready;
	ale_level_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/audio_level_envelope.sv */
// a sample without block_end is absorbed, one item per cycle while the block is idle
// a sample with block_end yields its result through a bit-serial divide of the SW-bit sum
// (SW = clog2(MAX_BLOCK+1) + 15), a bit-serial sqrt and a 4-tap mac
// no item is taken until that result is loaded, which waits while an earlier one is untaken
// reset clears the running sum, count, volume history and the output valid flag
`include "audio_level_envelope_macros.svh"

module audio_level_envelope #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	ale_sample_if.sink   samples,
	ale_level_if.source  levels
);
	import ale_pkg::*;

	// count must hold MAX_BLOCK itself, sum holds MAX_BLOCK * 32768
	localparam int CW       = $clog2(MAX_BLOCK + 1);
	localparam int SW       = CW + 15;
	localparam int STW      = $clog2(SW);
	localparam int ACC_W    = 33;
	localparam int MAC_LAST = HIST_DEPTH;

	ale_state_t state_q, state_d;
	logic [STW-1:0] cnt_q;

	// block accumulation; sum_q doubles as dividend / quotient shift register
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] rem_q;

	// square root: radicand shifts out two bits per step
	logic [31:0] rad_q;
	logic [15:0] root_q;
	logic [16:0] srem_q;

	logic [15:0] hist_q [HIST_DEPTH];

	logic [31:0]      prod_q;
	logic [ACC_W-1:0] acc_q;

	logic        out_valid_q;
	logic [15:0] level_q;
	logic [15:0] volume_q;

	logic        in_ready;
	logic        accept;
	logic        out_load;
	logic [15:0] raw;
	logic [15:0] mag;
	logic        room;

	logic [CW:0]   div_trial;
	logic          div_ge;
	logic [CW:0]   div_diff;
	logic [CW-1:0] div_rem;
	logic [SW-1:0] quot;
	logic [15:0]   mean;

	logic [18:0] sq_trial;
	logic [18:0] sq_test;
	logic        sq_ge;
	logic [18:0] sq_diff;
	logic [15:0] root_next;

	logic [31:0] mac_prod;

	assign accept = samples.valid && in_ready;
	assign samples.ready = in_ready;

	// magnitude of the two's complement sample, most negative gives 32768
	assign raw = samples.data.sample;
	assign mag = raw[15] ? (~raw + 16'd1) : raw;

	// samples past MAX_BLOCK in one block are dropped
	assign room = count_q < CW'(MAX_BLOCK);

	// restoring divide, one quotient bit per cycle, msb first
	assign div_trial = {rem_q, sum_q[SW-1]};
	assign div_ge    = div_trial >= {1'b0, count_q};
	assign div_diff  = div_ge ? (div_trial - {1'b0, count_q}) : div_trial;
	assign div_rem   = div_diff[CW-1:0];
	assign quot      = {sum_q[SW-2:0], div_ge};
	assign mean      = (quot > SW'(VOL_MAX)) ? VOL_MAX : quot[15:0];

	// digit-by-digit square root, one root bit per cycle
	assign sq_trial  = {srem_q, rad_q[31:30]};
	assign sq_test   = {1'b0, root_q, 2'b01};
	assign sq_ge     = sq_trial >= sq_test;
	assign sq_diff   = sq_ge ? (sq_trial - sq_test) : sq_trial;
	assign root_next = {root_q[14:0], sq_ge};

	// one history tap per cycle through a single 16x16 multiplier
	assign mac_prod = {16'd0, ale_weight(cnt_q[1:0])} * {16'd0, hist_q[cnt_q[1:0]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (samples.valid && samples.data.block_end) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == '0) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (cnt_q == STW'(MAC_LAST)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				out_load = !out_valid_q || levels.ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			hist_q      <= '{default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							sum_q   <= sum_q + SW'(mag);
							count_q <= count_q + CW'(1);
						end
						cnt_q <= STW'(SW - 1);
					end
				end
				ST_DIV: begin
					sum_q <= quot;
					cnt_q <= (cnt_q == '0) ? STW'(SQRT_STEPS - 1) : cnt_q - STW'(1);
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						// delay line, index 3 newest
						hist_q[0] <= hist_q[1];
						hist_q[1] <= hist_q[2];
						hist_q[2] <= hist_q[3];
						hist_q[3] <= root_next;
					end else begin
						cnt_q <= cnt_q - STW'(1);
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + STW'(1);
				end
				ST_OUT: begin
					if (out_load) begin
						sum_q   <= '0;
						count_q <= '0;
						cnt_q   <= '0;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_rem;
				if (cnt_q == '0) begin
					// radicand is mean << 15
					rad_q  <= {1'b0, mean, 15'd0};
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[29:0], 2'b00};
				root_q <= root_next;
				srem_q <= sq_diff[16:0];
				acc_q  <= '0;
			end
			ST_MAC: begin
				// product of tap k is registered in prod_q, then summed into acc_q in the next cycle
				prod_q <= mac_prod;
				if (cnt_q != '0) begin
					acc_q <= acc_q + ACC_W'(prod_q);
				end
			end
			ST_OUT: begin
				if (out_load) begin
					level_q  <= acc_q[31:16];
					volume_q <= hist_q[3];
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign levels.valid       = out_valid_q;
	assign levels.data.level  = level_q;
	assign levels.data.volume = volume_q;

	`ALE_ASSERT_IMPL(a_count_bound, state_q == ST_IDLE, count_q <= CW'(MAX_BLOCK))
	`ALE_ASSERT_IMPL(a_div_nonzero, state_q == ST_DIV, count_q != '0)
	`ALE_ASSERT_NEXT(a_end_starts_div, accept && samples.data.block_end, state_q == ST_DIV)
	`ALE_ASSERT_IMPL(a_rise_from_out, $rose(out_valid_q), $past(state_q) == ST_OUT)
	`ALE_ASSERT_IMPL(a_volume_range, out_valid_q, volume_q <= VOL_MAX)

endmodule

/* tb/audio_level_envelope_checker.sv */
module audio_level_envelope_checker #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	ale_sample_if       samples,
	ale_level_if        levels,
	output int unsigned mismatches,
	output int unsigned pending
);
	import ale_pkg::*;

	logic [27:0] abs_total;
	logic [12:0] taken;
	logic [15:0] vol_line [HIST_DEPTH];
	ale_level_t  level_queue [$];
	int unsigned fail_total = 0;
	int unsigned queued = 0;

	assign mismatches = fail_total;
	assign pending    = queued;

	// bit-by-bit floor square root, result fits 16 bits for inputs up to 2^30
	function automatic logic [15:0] floor_root(input logic [31:0] radicand);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int k = 15; k >= 0; k--) begin
			trial = root | (32'd1 << k);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		return root[15:0];
	endfunction

	task automatic absorb(input ale_sample_t item);
		logic [16:0] mag;
		logic [31:0] mean;
		logic [15:0] vol;
		logic [63:0] acc;
		ale_level_t  want;
		mag = item.sample[15] ? 17'(17'h10000 - {1'b0, item.sample}) : {1'b0, item.sample};
		// samples past the block limit are dropped, the final one too
		if (taken < 13'(MAX_BLOCK)) begin
			abs_total = abs_total + 28'(mag);
			taken     = taken + 13'd1;
		end
		if (item.block_end) begin
			mean = 32'(abs_total) / 32'(taken);
			if (mean > 32'(VOL_MAX)) begin
				mean = 32'(VOL_MAX);
			end
			vol = floor_root(mean << 15);
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				vol_line[i] = vol_line[i + 1];
			end
			vol_line[HIST_DEPTH - 1] = vol;
			acc = 64'(W_OLDEST) * 64'(vol_line[0]) + 64'(W_OLD) * 64'(vol_line[1])
				+ 64'(W_RECENT) * 64'(vol_line[2]) + 64'(W_NEWEST) * 64'(vol_line[3]);
			want.level  = acc[31:16];
			want.volume = vol;
			level_queue.push_back(want);
			abs_total = '0;
			taken     = '0;
		end
	endtask

	task automatic compare_level(input ale_level_t got);
		ale_level_t want;
		if (level_queue.size() == 0) begin
			$error("level item with nothing expected: level %0d volume %0d",
				got.level, got.volume);
			fail_total++;
		end else begin
			want = level_queue.pop_front();
			if (got.level !== want.level) begin
				$error("level: expected %0d, got %0d", want.level, got.level);
				fail_total++;
			end
			if (got.volume !== want.volume) begin
				$error("volume: expected %0d, got %0d", want.volume, got.volume);
				fail_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_total = '0;
			taken     = '0;
			foreach (vol_line[i]) begin
				vol_line[i] = '0;
			end
			level_queue.delete();
		end else begin
			if (samples.valid && samples.ready) begin
				absorb(samples.data);
			end
			if (levels.valid && levels.ready) begin
				compare_level(levels.data);
			end
		end
		queued = level_queue.size();
	end

endmodule

/* tb/audio_level_envelope_tb.sv */
module audio_level_envelope_tb;
	import ale_pkg::*;

	localparam int MAX_BLOCK = 4096;

	// long receiver hold-off, so the block runs full and stops taking samples
	localparam int HOLD_CYCLES = 400;

	// how the sample values of one block are drawn
	typedef enum int {
		MIX_FULL,
		MIX_QUIET,
		MIX_EDGES,
		MIX_FLOOR
	} sample_mix_t;

	logic        clk;
	logic        arst_n;
	int unsigned fail_total;
	int unsigned levels_due;

	// idle and stall rates in percent, changed per phase by the stimulus process
	int send_idle_pct;
	int recv_stall_pct;
	bit pressure_phase;
	int unsigned sent_items;

	ale_sample_if sample_ch();
	ale_level_if  level_ch();

	audio_level_envelope #(
		.MAX_BLOCK(MAX_BLOCK)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.levels (level_ch)
	);

	// watches both channels, predicts every level item and counts mismatches
	audio_level_envelope_checker #(
		.MAX_BLOCK(MAX_BLOCK)
	) level_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.levels    (level_ch),
		.mismatches(fail_total),
		.pending   (levels_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// draw one sample value; quiet keeps the magnitude at most 128
	function automatic logic [15:0] draw_sample(input sample_mix_t mix);
		logic [15:0] r;
		r = 16'($urandom);
		case (mix)
			MIX_QUIET: begin
				r = {{8{r[7]}}, r[7:0]};
			end
			MIX_EDGES: begin
				case ($urandom_range(0, 4))
					0: r = 16'h8000;
					1: r = 16'h7fff;
					2: r = 16'h0000;
					3: r = 16'hffff;
					default: r = 16'h0001;
				endcase
			end
			MIX_FLOOR: begin
				r = 16'h8000;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// offer one item and hold it until the block takes it
	task automatic offer(input logic [15:0] value, input logic last);
		// random idle cycles ahead of the item
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid          <= 1'b1;
		sample_ch.data.sample    <= value;
		sample_ch.data.block_end <= last;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
		sent_items++;
	endtask

	// one audio block, block_end on its last sample
	task automatic send_block(input int len, input sample_mix_t mix);
		for (int i = 0; i < len; i++) begin
			offer(draw_sample(mix), i == len - 1);
		end
	endtask

	// random blocks, mostly short so that level items come often
	task automatic run_phase(input int idle_pct, input int stall_pct, input int unsigned count);
		int unsigned start;
		int pick;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = sent_items;
		while (sent_items - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(1, 8);
			end else if (pick < 95) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(41, 120);
			end
			send_block(len, sample_mix_t'($urandom_range(0, 3)));
		end
	endtask

	// receiver: random stalls, plus one long hold-off in the pressure phase
	initial begin
		bit held_once;
		held_once = 1'b0;
		level_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pressure_phase && !held_once) begin
				held_once = 1'b1;
				level_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			level_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			@(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		arst_n          = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		pressure_phase  = 1'b0;
		sent_items      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-sample blocks: silence, most negative, most positive
		offer(16'h0000, 1'b1);
		offer(16'h8000, 1'b1);
		offer(16'h7fff, 1'b1);
		// full scale four times in a row fills the history, level at its top
		repeat (4) offer(16'h8000, 1'b1);
		// mixed signs, small and large
		offer(16'h0001, 1'b0);
		offer(16'hffff, 1'b0);
		offer(16'h7fff, 1'b1);
		// smallest nonzero mean
		offer(16'h0001, 1'b1);
		// block whose last sample is silent
		repeat (3) offer(16'h8000, 1'b0);
		offer(16'h0000, 1'b1);
		offer(16'h0003, 1'b0);
		offer(16'hfffe, 1'b0);
		offer(16'h0004, 1'b1);

		// no idling, starting under a long receiver hold-off with short blocks
		pressure_phase = 1'b1;
		repeat (12) send_block(1, MIX_FULL);
		run_phase(0, 0, 220);
		pressure_phase = 1'b0;
		// sender mostly idle
		run_phase(86, 0, 150);
		// receiver mostly stalled
		run_phase(0, 86, 200);
		// both sides idling now and then
		run_phase(35, 35, 250);
		sample_ch.valid <= 1'b0;

		// let the checker register the last item, then drain
		@(posedge clk);
		while (levels_due != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (fail_total == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_sample_if.sv
rtl/ale_level_if.sv
rtl/audio_level_envelope.sv
tb/audio_level_envelope_checker.sv
tb/audio_level_envelope_tb.sv
